### rtl/s2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package s2d_pkg;

  localparam int MaxDigits = 10;
  localparam int DigitW    = 4;
  localparam int CntW      = 4;

  localparam logic [7:0]  CharMinus  = 8'd45;
  localparam logic [7:0]  CharZero   = 8'd48;
  // floor(v / 10) == (v * Recip) >> RecipShift for every 32-bit v
  localparam logic [31:0] Recip      = 32'hCCCC_CCCD;
  localparam int          RecipShift = 35;

  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } s2d_item_t;

  typedef struct packed {
    logic                              neg;
    logic [CntW-1:0]                   ndig;
    logic [MaxDigits-1:0][DigitW-1:0]  digits;  // least significant first
  } s2d_text_t;

endpackage

### rtl/signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a 32-bit two's complement integer into its decimal ASCII text.
//
//   channel  dir  tdata                         tuser  tlast
//   s_*      in   [31:0] value                  -      -
//   m_*      out  [7:0] char_code               -      last
//
// one request yields 1 to 11 characters, one per cycle within a text while
// m_tready is high; the output sequencer sets the sustained rate, and digit
// extraction runs in parallel for the next request through one reciprocal
// multiplier
// rst is synchronous and clears all handshake state; the queue lets requests be
// taken in while conversion or output stalls, and a long output stall fills the
// front, the queue and the converter and then drops s_tready
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top import s2d_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] char_code
  output logic        m_tlast
);

  logic      f_valid;
  logic      f_ready;
  s2d_item_t f_item;
  logic      c_valid;
  logic      c_ready;
  s2d_item_t c_item;
  logic      t_valid;
  logic      t_ready;
  s2d_text_t t_text;

  s2d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  s2d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_item  (c_item)
  );

  s2d_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (c_valid),
    .in_ready   (c_ready),
    .in_item    (c_item),
    .text_valid (t_valid),
    .text_ready (t_ready),
    .text       (t_text)
  );

  s2d_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .text_valid (t_valid),
    .text_ready (t_ready),
    .text       (t_text),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

### rtl/s2d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_front
// Input stage: takes a request, splits it into sign and 32-bit magnitude.
// ----------------------------------------------------------------------------
module s2d_front import s2d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  output logic        q_valid,
  input  logic        q_ready,
  output s2d_item_t   q_item
);

  logic      vld;
  s2d_item_t item;

  assign s_tready = !vld || q_ready;
  assign q_valid  = vld;
  assign q_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_tready) begin
      vld <= s_tvalid;
    end
  end

  // magnitude of the most negative value is 2^31, still fits unsigned
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.neg <= s_tdata[31];
      item.mag <= s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;
    end
  end

endmodule

### rtl/s2d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_queue
// Small first-in first-out buffer between the front and the converter.
// ----------------------------------------------------------------------------
module s2d_queue import s2d_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  s2d_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output s2d_item_t out_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  s2d_item_t        mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CntW'(Depth));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

### rtl/s2d_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_conv
// Digit extraction: one divide by ten per cycle through a reciprocal multiply.
// ----------------------------------------------------------------------------
module s2d_conv import s2d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  s2d_item_t in_item,
  output logic      text_valid,
  input  logic      text_ready,
  output s2d_text_t text
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]                        state;
  logic [31:0]                       v;
  logic                              neg;
  logic [CntW-1:0]                   ndig;
  logic [MaxDigits-1:0][DigitW-1:0]  digits;

  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] ten_quo;
  logic [31:0] rem;

  assign prod    = {32'd0, v} * {32'd0, Recip};
  assign quo     = {{RecipShift - 32{1'b0}}, prod[63:RecipShift]};
  assign ten_quo = (quo << 3) + (quo << 1);
  assign rem     = v - ten_quo;

  assign in_ready    = (state == StIdle);
  assign text_valid  = (state == StDone);
  assign text.neg    = neg;
  assign text.ndig   = ndig;
  assign text.digits = digits;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      case (state)
        StIdle: begin
          if (in_valid) begin
            state <= StRun;
          end
        end
        StRun: begin
          // zero still yields one digit, stored in the cycle the quotient is seen as zero
          if (quo == 32'd0) begin
            state <= StDone;
          end
        end
        StDone: begin
          if (text_ready) begin
            state <= StIdle;
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == StIdle && in_valid) begin
      v    <= in_item.mag;
      neg  <= in_item.neg;
      ndig <= '0;
    end else if (state == StRun) begin
      digits[ndig] <= rem[DigitW-1:0];
      ndig         <= ndig + CntW'(1);
      v            <= quo;
    end
  end

endmodule

### rtl/s2d_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_emit
// Output sequencer: sign, then digits most significant first, into a
// registered result stage.
// ----------------------------------------------------------------------------
module s2d_emit import s2d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_ready,
  input  s2d_text_t  text,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  logic                              neg_pend;
  logic                              dig_pend;
  logic [CntW-1:0]                   ptr;
  logic [MaxDigits-1:0][DigitW-1:0]  digits;
  logic                              busy;
  logic                              adv;
  logic                              emit_minus;
  logic                              emit_digit;
  logic                              load;

  assign busy       = neg_pend || dig_pend;
  assign text_ready = !busy;
  assign adv        = !m_tvalid || m_tready;
  assign emit_minus = adv && neg_pend;
  assign emit_digit = adv && !neg_pend && dig_pend;
  assign load       = text_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      neg_pend <= 1'b0;
      dig_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        m_tvalid <= emit_minus || emit_digit;
      end
      if (emit_minus) begin
        neg_pend <= 1'b0;
      end
      if (emit_digit && ptr == '0) begin
        dig_pend <= 1'b0;
      end
      if (load) begin
        neg_pend <= text.neg;
        dig_pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ptr    <= text.ndig - CntW'(1);
      digits <= text.digits;
    end else if (emit_digit && ptr != '0) begin
      ptr <= ptr - CntW'(1);
    end
    if (emit_minus) begin
      m_tdata <= CharMinus;
      m_tlast <= 1'b0;
    end else if (emit_digit) begin
      m_tdata <= CharZero + {4'd0, digits[ptr]};
      m_tlast <= (ptr == '0);
    end
  end

endmodule

### rtl/s2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_checker
// Port-level checks on the character stream of the conversion block.
// ----------------------------------------------------------------------------
module s2d_checker import s2d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast
);

  logic at_start;
  logic after_minus;
  logic first_digit;
  logic unused_in;

  assign first_digit = at_start || after_minus;
  assign unused_in   = s_tvalid ^ s_tready ^ (^s_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start    <= 1'b1;
      after_minus <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      at_start    <= m_tlast;
      after_minus <= (m_tdata == CharMinus);
    end
  end

  // a stalled character holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled character changed");

  a_charset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata == CharMinus ||
                 (m_tdata >= CharZero && m_tdata <= CharZero + 8'd9))
    else $error("character outside sign and digits");

  // sign only opens a text and never ends it
  a_minus_pos: assert property (@(posedge clk) disable iff (rst || unused_in === 1'bx)
    m_tvalid && m_tdata == CharMinus |-> at_start && !m_tlast)
    else $error("misplaced minus sign");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && first_digit && m_tdata == CharZero |-> m_tlast)
    else $error("leading zero in text");

endmodule

bind signed_int_to_decimal_ascii_top s2d_checker u_s2d_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### test/tb_signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_top
// Streams signed 32-bit integers into the decimal text converter and checks
// every ASCII character and its end-of-text flag against a local model.
// Covers directed corner values, random values of every digit count, random
// stalls on both sides, one long output stall, and a stretch with no stalls.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_top;
  import s2d_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int RandomItems  = 450;
  localparam int IdlePct      = 36;
  localparam int CalmStart    = 2000;
  localparam int CalmEnd      = 3200;
  localparam int HoldStart    = 800;
  localparam int HoldCycles   = 300;
  localparam int DrainCycles  = 40;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] char_code
  logic        m_tlast;

  logic [31:0] value_queue[$];
  text_char_t  char_queue[$];

  int cycle_cnt    = 0;
  int mismatches   = 0;
  int requests     = 0;
  int negatives    = 0;
  int chars_seen   = 0;
  int longest_text = 0;
  int hold_left    = 0;

  signed_int_to_decimal_ascii_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit calm_now();
    return cycle_cnt >= CalmStart && cycle_cnt < CalmEnd;
  endfunction

  function automatic bit idle_now();
    return !calm_now() && ($urandom_range(99) < IdlePct);
  endfunction

  // decimal text of one request, most significant character first
  function automatic void queue_text(input logic [31:0] value);
    logic        neg;
    logic [32:0] mag;
    logic [3:0]  digit[MaxDigits];
    int          n;
    text_char_t  c;
    n   = 0;
    neg = value[31];
    mag = neg ? (33'h1_0000_0000 - {1'b0, value}) : {1'b0, value};
    do begin
      digit[n] = 4'(mag % 10);
      mag      = mag / 10;
      n++;
    end while (mag != 0);
    if (neg) begin
      c.code = CharMinus;
      c.last = 1'b0;
      char_queue.push_back(c);
      negatives++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.code = CharZero + 8'(digit[k]);
      c.last = (k == 0);
      char_queue.push_back(c);
    end
    if (n + int'(neg) > longest_text) longest_text = n + int'(neg);
  endfunction

  // random value with a chosen digit count, so short and long texts both occur
  function automatic logic [31:0] random_value();
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    if ($urandom_range(99) < 20) return $urandom;
    ndig = $urandom_range(10, 1);
    lo   = 1;
    for (int i = 1; i < ndig; i++) lo = lo * 10;
    hi   = (ndig == 10) ? 32'd2147483647 : lo * 10 - 1;
    if (ndig == 1) lo = 0;
    mag  = $urandom_range(hi, lo);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // driver: holds a request until accepted, idles between requests at random
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        queue_text(s_tdata);
        value_queue.pop_front();
        requests++;
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (value_queue.size() > 0 && !idle_now()) begin
        s_tvalid <= 1'b1;
        s_tdata  <= value_queue[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to fill the block up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (cycle_cnt == HoldStart) hold_left = HoldCycles;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !idle_now();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      chars_seen++;
      if (char_queue.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected char: expected none, actual %0d last %0b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = char_queue.pop_front();
        if (m_tdata !== want.code || m_tlast !== want.last) begin
          mismatches++;
          $display("%0t: char mismatch: expected %0d last %0b, actual %0d last %0b",
                   $time, want.code, want.last, m_tdata, m_tlast);
        end
      end
    end
  end

  initial begin
    // zero, single digits, digit-count boundaries, both extremes, bit patterns
    value_queue.push_back(32'd0);
    value_queue.push_back(32'd1);
    value_queue.push_back(-32'sd1);
    value_queue.push_back(32'd9);
    value_queue.push_back(32'd10);
    value_queue.push_back(-32'sd10);
    value_queue.push_back(32'd99);
    value_queue.push_back(32'd100);
    value_queue.push_back(-32'sd100);
    value_queue.push_back(32'd999999999);
    value_queue.push_back(32'd1000000000);
    value_queue.push_back(-32'sd1000000000);
    value_queue.push_back(32'd1234567890);
    value_queue.push_back(-32'sd1234567890);
    value_queue.push_back(32'h7FFF_FFFF);
    value_queue.push_back(32'h8000_0000);
    value_queue.push_back(32'h8000_0001);
    value_queue.push_back(32'h5555_5555);
    value_queue.push_back(32'hAAAA_AAAA);
    value_queue.push_back(32'd4294967286);
    value_queue.push_back(32'd1000000001);
    for (int i = 0; i < RandomItems; i++) value_queue.push_back(random_value());

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (value_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (char_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("converted %0d values (%0d negative), %0d characters, longest text %0d",
             requests, negatives, chars_seen, longest_text);
    $display("included a %0d-cycle output hold-off and a stall-free stretch", HoldCycles);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
